### rtl/frce_pkg.sv
// Shared field widths, command codes, status codes and register indexes of the flash engine.
package frce_pkg;

   localparam int MODE_W      = 3;
   localparam int ADDR_W      = 15;
   localparam int LEN_W       = 16;
   localparam int DATA_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [LEN_W-1:0] REGION_SIZE_RESET = 16'h8000;
   localparam logic [DATA_W-1:0] ERASED_BYTE      = 8'hFF;

   typedef enum logic [MODE_W-1:0] {
      MODE_ERASE       = 3'd0,
      MODE_OPEN_WRITE  = 3'd1,
      MODE_WRITE_BYTE  = 3'd2,
      MODE_OPEN_READ   = 3'd3,
      MODE_READ_BYTE   = 3'd4,
      MODE_OPEN_VERIFY = 3'd5,
      MODE_VERIFY_BYTE = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REJECT   = 2'd1,
      STATUS_NO_XFER  = 2'd2,
      STATUS_MISMATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_READ   = 2'd2,
      KIND_VERIFY = 2'd3
   } kind_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_SIZE = 1'd1;

endpackage

### rtl/frce_mod.sv
// Remainder unit for a power-of-two divisor: registers the low bits of the operand on start.
module frce_mod #(
   parameter int DIVISOR = 64,
   parameter int IN_W    = 16,
   parameter int OUT_W   = $clog2(DIVISOR)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [IN_W-1:0]  operand,
   output logic             done,
   output logic [OUT_W-1:0] remainder
);

   logic [OUT_W-1:0] r_ff, r_in;
   logic             done_ff, done_in;

   always_comb begin
      r_in    = r_ff;
      done_in = start;
      if (start) begin
         // With a power-of-two divisor the remainder is the low bits of the operand.
         r_in = OUT_W'(operand);
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = r_ff;

   a_power_of_two: assert property (@(posedge clock)
      (1 << OUT_W) == DIVISOR)
      else $error("divisor is not two to the power of the remainder width");

   a_done_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> done_ff)
      else $error("remainder done did not follow start");

   a_done_needs_start: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(start))
      else $error("remainder done without a start");

   a_low_bits: assert property (@(posedge clock) disable iff (reset)
      start |=> (r_ff == OUT_W'($past(operand))))
      else $error("remainder is not the low bits of the operand");

endmodule

### rtl/flash_region_command_engine.sv
// Flash region command engine: erase, page write, read and verify over a window of a byte store.
// A command is decoded after it is accepted; open write and erase then check alignment,
// erase reduces its base address and sweeps its length, read and verify bytes reduce the
// address and read the store, and a page-filling write byte writes the buffered page back
// before its result. Results cannot be held off; a new command is taken at the edge
// that takes one. After reset busy stays high while the store is swept to 0xFF.
module flash_region_command_engine #(
   parameter int DEVICE_BYTES = 32768,
   parameter int PAGE_BYTES   = 32,
   parameter int SECTOR_BYTES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [frce_pkg::MODE_W-1:0]          req_mode,
   input  logic [frce_pkg::ADDR_W-1:0]          req_address,
   input  logic [frce_pkg::LEN_W-1:0]           req_length,
   input  logic [frce_pkg::DATA_W-1:0]          req_data_byte,
   output logic                                 rsp_valid,
   output logic [frce_pkg::STATUS_W-1:0]        rsp_status,
   output logic [frce_pkg::DATA_W-1:0]          rsp_read_data,
   output logic                                 rsp_transfer_done,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [frce_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [frce_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int DEV_W = $clog2(DEVICE_BYTES);
   localparam int PF_W  = $clog2(PAGE_BYTES);
   localparam int SEC_W = $clog2(SECTOR_BYTES);
   localparam int SUM_W = frce_pkg::ADDR_W + 1;
   localparam int LW    = frce_pkg::LEN_W;
   localparam int AW    = frce_pkg::ADDR_W;
   localparam int DW    = frce_pkg::DATA_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_ALIGN,
      ST_ERASE_MOD,
      ST_ERASE,
      ST_PROG_MOD,
      ST_PROG,
      ST_PROG_TAIL,
      ST_BYTE_MOD,
      ST_BYTE_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [AW-1:0] region_base_ff, region_base_in;
   logic [LW-1:0] region_size_ff, region_size_in;

   // Transfer state
   logic [AW-1:0]          cursor_ff, cursor_in;
   logic [LW-1:0]          bytes_left_ff, bytes_left_in;
   frce_pkg::kind_type     open_kind_ff, open_kind_in;
   logic [PF_W-1:0]        page_fill_ff, page_fill_in;
   logic [AW-1:0]          page_start_ff, page_start_in;

   // Latched command
   logic [frce_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [AW-1:0]               address_ff, address_in;
   logic [LW-1:0]               length_ff, length_in;
   logic [DW-1:0]               data_ff, data_in;

   // Walk over the store
   logic [DEV_W-1:0] walk_addr_ff, walk_addr_in;
   logic [LW-1:0]    walk_left_ff, walk_left_in;
   logic [PF_W-1:0]  pi_ff, pi_in;
   logic             pbv_ff, pbv_in;
   logic             done_pend_ff, done_pend_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   frce_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [DW-1:0]          rsp_read_data_ff, rsp_read_data_in;
   logic                   rsp_transfer_done_ff, rsp_transfer_done_in;

   // Memories
   logic [DW-1:0] flash_mem [DEVICE_BYTES];
   logic [DW-1:0] page_mem [PAGE_BYTES];
   logic [DW-1:0] fl_q_ff;
   logic [DW-1:0] pb_q_ff;
   logic          fl_we;
   logic [DW-1:0] fl_wdata;
   logic          pb_we;

   // Remainder units
   logic             dev_start, dev_done;
   logic [AW-1:0]    dev_off;
   logic [SUM_W-1:0] dev_operand;
   logic [DEV_W-1:0] dev_rem;
   logic             sec_start, sec_a_done, sec_l_done;
   logic [SEC_W-1:0] sec_a_rem, sec_l_rem;
   logic             pg_start, pg_a_done, pg_l_done;
   logic [PF_W-1:0]  pg_a_rem, pg_l_rem;

   logic             accept;
   logic             range_bad;
   logic             is_erase;
   logic             align_done;
   logic             aligned;
   logic             last_byte;
   logic             page_full;
   logic [AW-1:0]    page_start_eff;
   logic [DEV_W-1:0] walk_next;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign range_bad = (length_ff == '0) ||
      (({2'b0, address_ff} + {1'b0, length_ff}) > {1'b0, region_size_ff});
   assign is_erase   = (mode_ff == frce_pkg::MODE_ERASE);
   assign align_done = is_erase ? (sec_a_done && sec_l_done) : (pg_a_done && pg_l_done);
   assign aligned    = is_erase ? (sec_a_rem == '0 && sec_l_rem == '0)
                                : (pg_a_rem == '0 && pg_l_rem == '0);
   assign last_byte  = (bytes_left_ff == LW'(1));
   assign page_full  = (({1'b0, page_fill_ff} + (PF_W + 1)'(1)) == (PF_W + 1)'(PAGE_BYTES));
   assign page_start_eff = (page_fill_ff == '0) ? cursor_ff : page_start_ff;
   assign walk_next  = (walk_addr_ff == DEV_W'(DEVICE_BYTES - 1)) ? '0
                                                                   : walk_addr_ff + DEV_W'(1);
   assign dev_operand = {1'b0, region_base_ff} + {1'b0, dev_off};

   assign fl_we    = (state_ff == ST_CLEAR) || (state_ff == ST_ERASE) || pbv_ff;
   assign fl_wdata = pbv_ff ? pb_q_ff : frce_pkg::ERASED_BYTE;

   always_comb begin
      state_in             = state_ff;
      region_base_in       = region_base_ff;
      region_size_in       = region_size_ff;
      cursor_in            = cursor_ff;
      bytes_left_in        = bytes_left_ff;
      open_kind_in         = open_kind_ff;
      page_fill_in         = page_fill_ff;
      page_start_in        = page_start_ff;
      mode_in              = mode_ff;
      address_in           = address_ff;
      length_in            = length_ff;
      data_in              = data_ff;
      walk_addr_in         = walk_addr_ff;
      walk_left_in         = walk_left_ff;
      pi_in                = pi_ff;
      pbv_in               = (state_ff == ST_PROG);
      done_pend_in         = done_pend_ff;
      rsp_valid_in         = 1'b0;
      rsp_status_in        = frce_pkg::STATUS_OK;
      rsp_read_data_in     = '0;
      rsp_transfer_done_in = 1'b0;
      dev_start            = 1'b0;
      dev_off              = cursor_ff;
      sec_start            = 1'b0;
      pg_start             = 1'b0;
      pb_we                = 1'b0;

      if (csr_valid) begin
         if (csr_index == frce_pkg::CSR_REGION_BASE) begin
            region_base_in = csr_wdata[AW-1:0];
         end else begin
            region_size_in = csr_wdata;
         end
      end

      if (fl_we) begin
         walk_addr_in = walk_next;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            if (walk_addr_ff == DEV_W'(DEVICE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in    = req_mode;
               address_in = req_address;
               length_in  = req_length;
               data_in    = req_data_byte;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (mode_ff)
               frce_pkg::MODE_ERASE: begin
                  if (range_bad) begin
                     rsp_status_in = frce_pkg::STATUS_REJECT;
                  end else begin
                     rsp_valid_in = 1'b0;
                     sec_start    = 1'b1;
                     state_in     = ST_ALIGN;
                  end
               end
               frce_pkg::MODE_OPEN_WRITE: begin
                  if (range_bad) begin
                     rsp_status_in = frce_pkg::STATUS_REJECT;
                     open_kind_in  = frce_pkg::KIND_NONE;
                  end else begin
                     rsp_valid_in = 1'b0;
                     pg_start     = 1'b1;
                     state_in     = ST_ALIGN;
                  end
               end
               frce_pkg::MODE_OPEN_READ, frce_pkg::MODE_OPEN_VERIFY: begin
                  if (range_bad) begin
                     rsp_status_in = frce_pkg::STATUS_REJECT;
                     open_kind_in  = frce_pkg::KIND_NONE;
                  end else begin
                     open_kind_in  = (mode_ff == frce_pkg::MODE_OPEN_READ) ?
                                     frce_pkg::KIND_READ : frce_pkg::KIND_VERIFY;
                     cursor_in     = address_ff;
                     bytes_left_in = length_ff;
                     page_fill_in  = '0;
                     page_start_in = address_ff;
                  end
               end
               frce_pkg::MODE_WRITE_BYTE: begin
                  if (open_kind_ff != frce_pkg::KIND_WRITE) begin
                     rsp_status_in = frce_pkg::STATUS_NO_XFER;
                  end else begin
                     pb_we         = 1'b1;
                     page_start_in = page_start_eff;
                     cursor_in     = cursor_ff + AW'(1);
                     bytes_left_in = bytes_left_ff - LW'(1);
                     done_pend_in  = last_byte;
                     if (last_byte) begin
                        open_kind_in = frce_pkg::KIND_NONE;
                     end
                     if (page_full) begin
                        // The buffered page goes to the store before the result is given.
                        page_fill_in = '0;
                        dev_start    = 1'b1;
                        dev_off      = page_start_eff;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_PROG_MOD;
                     end else begin
                        page_fill_in         = last_byte ? '0 : page_fill_ff + PF_W'(1);
                        rsp_transfer_done_in = last_byte;
                     end
                  end
               end
               frce_pkg::MODE_READ_BYTE, frce_pkg::MODE_VERIFY_BYTE: begin
                  if ((mode_ff == frce_pkg::MODE_READ_BYTE &&
                       open_kind_ff != frce_pkg::KIND_READ) ||
                      (mode_ff == frce_pkg::MODE_VERIFY_BYTE &&
                       open_kind_ff != frce_pkg::KIND_VERIFY)) begin
                     rsp_status_in = frce_pkg::STATUS_NO_XFER;
                  end else begin
                     rsp_valid_in = 1'b0;
                     dev_start    = 1'b1;
                     state_in     = ST_BYTE_MOD;
                  end
               end
               default: begin
                  rsp_status_in = frce_pkg::STATUS_REJECT;
               end
            endcase
         end
         ST_ALIGN: begin
            if (align_done) begin
               if (!aligned) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = frce_pkg::STATUS_REJECT;
                  state_in      = ST_IDLE;
                  if (!is_erase) begin
                     open_kind_in = frce_pkg::KIND_NONE;
                  end
               end else if (is_erase) begin
                  dev_start = 1'b1;
                  dev_off   = address_ff;
                  state_in  = ST_ERASE_MOD;
               end else begin
                  open_kind_in  = frce_pkg::KIND_WRITE;
                  cursor_in     = address_ff;
                  bytes_left_in = length_ff;
                  page_fill_in  = '0;
                  page_start_in = address_ff;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_ERASE_MOD: begin
            if (dev_done) begin
               walk_addr_in = dev_rem;
               walk_left_in = length_ff;
               state_in     = ST_ERASE;
            end
         end
         ST_ERASE: begin
            walk_left_in = walk_left_ff - LW'(1);
            if (walk_left_ff == LW'(1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_PROG_MOD: begin
            if (dev_done) begin
               walk_addr_in = dev_rem;
               pi_in        = '0;
               state_in     = ST_PROG;
            end
         end
         ST_PROG: begin
            // Each buffer read is registered, and its byte is written to the store in the next cycle.
            pi_in = pi_ff + PF_W'(1);
            if (pi_ff == PF_W'(PAGE_BYTES - 1)) begin
               state_in = ST_PROG_TAIL;
            end
         end
         ST_PROG_TAIL: begin
            rsp_valid_in         = 1'b1;
            rsp_transfer_done_in = done_pend_ff;
            state_in             = ST_IDLE;
         end
         ST_BYTE_MOD: begin
            if (dev_done) begin
               state_in = ST_BYTE_DONE;
            end
         end
         ST_BYTE_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (mode_ff == frce_pkg::MODE_VERIFY_BYTE && fl_q_ff != data_ff) begin
               rsp_status_in        = frce_pkg::STATUS_MISMATCH;
               rsp_transfer_done_in = 1'b1;
               open_kind_in         = frce_pkg::KIND_NONE;
            end else begin
               if (mode_ff == frce_pkg::MODE_READ_BYTE) begin
                  rsp_read_data_in = fl_q_ff;
               end
               cursor_in            = cursor_ff + AW'(1);
               bytes_left_in        = bytes_left_ff - LW'(1);
               rsp_transfer_done_in = last_byte;
               if (last_byte) begin
                  open_kind_in = frce_pkg::KIND_NONE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff              <= mode_in;
      address_ff           <= address_in;
      length_ff            <= length_in;
      data_ff              <= data_in;
      page_start_ff        <= page_start_in;
      walk_left_ff         <= walk_left_in;
      pi_ff                <= pi_in;
      done_pend_ff         <= done_pend_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_read_data_ff     <= rsp_read_data_in;
      rsp_transfer_done_ff <= rsp_transfer_done_in;
      if (reset) begin
         state_ff       <= ST_CLEAR;
         walk_addr_ff   <= '0;
         region_base_ff <= '0;
         region_size_ff <= frce_pkg::REGION_SIZE_RESET;
         cursor_ff      <= '0;
         bytes_left_ff  <= '0;
         open_kind_ff   <= frce_pkg::KIND_NONE;
         page_fill_ff   <= '0;
         pbv_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         walk_addr_ff   <= walk_addr_in;
         region_base_ff <= region_base_in;
         region_size_ff <= region_size_in;
         cursor_ff      <= cursor_in;
         bytes_left_ff  <= bytes_left_in;
         open_kind_ff   <= open_kind_in;
         page_fill_ff   <= page_fill_in;
         pbv_ff         <= pbv_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Store: one write port on the walk address, one registered read port on the reduced address.
   always_ff @(posedge clock) begin
      if (fl_we) begin
         flash_mem[walk_addr_ff] <= fl_wdata;
      end
      fl_q_ff <= flash_mem[dev_rem];
   end

   always_ff @(posedge clock) begin
      if (pb_we) begin
         page_mem[page_fill_ff] <= data_ff;
      end
      pb_q_ff <= page_mem[pi_ff];
   end

   frce_mod #(
      .DIVISOR (DEVICE_BYTES),
      .IN_W    (SUM_W),
      .OUT_W   (DEV_W)
   ) u_dev_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (dev_start),
      .operand   (dev_operand),
      .done      (dev_done),
      .remainder (dev_rem)
   );

   frce_mod #(
      .DIVISOR (SECTOR_BYTES),
      .IN_W    (LW),
      .OUT_W   (SEC_W)
   ) u_sec_addr_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (sec_start),
      .operand   ({1'b0, address_ff}),
      .done      (sec_a_done),
      .remainder (sec_a_rem)
   );

   frce_mod #(
      .DIVISOR (SECTOR_BYTES),
      .IN_W    (LW),
      .OUT_W   (SEC_W)
   ) u_sec_len_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (sec_start),
      .operand   (length_ff),
      .done      (sec_l_done),
      .remainder (sec_l_rem)
   );

   frce_mod #(
      .DIVISOR (PAGE_BYTES),
      .IN_W    (LW),
      .OUT_W   (PF_W)
   ) u_pg_addr_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (pg_start),
      .operand   ({1'b0, address_ff}),
      .done      (pg_a_done),
      .remainder (pg_a_rem)
   );

   frce_mod #(
      .DIVISOR (PAGE_BYTES),
      .IN_W    (LW),
      .OUT_W   (PF_W)
   ) u_pg_len_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (pg_start),
      .operand   (length_ff),
      .done      (pg_l_done),
      .remainder (pg_l_rem)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_transfer_done = rsp_transfer_done_ff;

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("two results from one command");

   a_done_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_transfer_done_ff) |-> (open_kind_ff == frce_pkg::KIND_NONE))
      else $error("transfer reported done but still open");

   a_read_data_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_read_data_ff != '0) |-> (rsp_status_ff == frce_pkg::STATUS_OK))
      else $error("read data returned with an error status");

   a_prog_writes: assert property (@(posedge clock) disable iff (reset)
      pbv_ff |-> (state_ff == ST_PROG || state_ff == ST_PROG_TAIL))
      else $error("page buffer write-back outside page programming");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result shown while the engine is still working");

endmodule

### tb/tb.sv
// Self-checking testbench for the flash region command engine: table-driven and random commands.
module tb;
   import frce_pkg::*;

   localparam int DEVICE_BYTES = 32768;
   localparam int PAGE_BYTES   = 32;
   localparam int SECTOR_BYTES = 64;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES  = 64;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic [DATA_W-1:0] data_byte;
   } command_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   read_data;
      logic                done;
   } outcome_t;

   // One table row; a row with a repeat count sends the item that many times with data + k.
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    length;
      logic [DATA_W-1:0]   data_byte;
      logic [5:0]          repeats;
      logic                typed;
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   read_data;
      logic                done;
   } plan_row_t;

   localparam int PLAN_ROWS = 28;
   localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
      '{MODE_READ_BYTE,   15'd0,     16'd0,     8'h00, 6'd1,  1'b1, STATUS_NO_XFER,  8'h00, 1'b0},
      '{MODE_UNUSED,      15'd32767, 16'd65535, 8'hFF, 6'd1,  1'b1, STATUS_REJECT,   8'h00, 1'b0},
      '{MODE_ERASE,       15'd0,     16'd0,     8'h00, 6'd1,  1'b1, STATUS_REJECT,   8'h00, 1'b0},
      '{MODE_ERASE,       15'd1,     16'd64,    8'h00, 6'd1,  1'b1, STATUS_REJECT,   8'h00, 1'b0},
      '{MODE_ERASE,       15'd0,     16'd96,    8'h00, 6'd1,  1'b1, STATUS_REJECT,   8'h00, 1'b0},
      '{MODE_ERASE,       15'd32704, 16'd128,   8'h00, 6'd1,  1'b1, STATUS_REJECT,   8'h00, 1'b0},
      '{MODE_ERASE,       15'd32704, 16'd64,    8'h00, 6'd1,  1'b1, STATUS_OK,       8'h00, 1'b0},
      '{MODE_OPEN_WRITE,  15'd16,    16'd32,    8'h00, 6'd1,  1'b1, STATUS_REJECT,   8'h00, 1'b0},
      '{MODE_OPEN_WRITE,  15'd0,     16'd0,     8'h00, 6'd1,  1'b1, STATUS_REJECT,   8'h00, 1'b0},
      '{MODE_OPEN_WRITE,  15'd32736, 16'd32,    8'h00, 6'd1,  1'b1, STATUS_OK,       8'h00, 1'b0},
      '{MODE_WRITE_BYTE,  15'd0,     16'd0,     8'hF0, 6'd32, 1'b0, STATUS_OK,       8'h00, 1'b0},
      '{MODE_WRITE_BYTE,  15'd0,     16'd0,     8'h00, 6'd1,  1'b1, STATUS_NO_XFER,  8'h00, 1'b0},
      '{MODE_OPEN_VERIFY, 15'd32736, 16'd32,    8'h00, 6'd1,  1'b1, STATUS_OK,       8'h00, 1'b0},
      '{MODE_VERIFY_BYTE, 15'd0,     16'd0,     8'hF0, 6'd32, 1'b0, STATUS_OK,       8'h00, 1'b0},
      '{MODE_OPEN_VERIFY, 15'd32736, 16'd32,    8'h00, 6'd1,  1'b1, STATUS_OK,       8'h00, 1'b0},
      '{MODE_VERIFY_BYTE, 15'd0,     16'd0,     8'h00, 6'd1,  1'b1, STATUS_MISMATCH, 8'h00, 1'b1},
      '{MODE_VERIFY_BYTE, 15'd0,     16'd0,     8'h00, 6'd1,  1'b1, STATUS_NO_XFER,  8'h00, 1'b0},
      '{MODE_OPEN_READ,   15'd32736, 16'd32,    8'h00, 6'd1,  1'b1, STATUS_OK,       8'h00, 1'b0},
      '{MODE_READ_BYTE,   15'd0,     16'd0,     8'h00, 6'd32, 1'b0, STATUS_OK,       8'h00, 1'b0},
      '{MODE_OPEN_READ,   15'd0,     16'd32768, 8'h00, 6'd1,  1'b1, STATUS_OK,       8'h00, 1'b0},
      '{MODE_READ_BYTE,   15'd0,     16'd0,     8'h00, 6'd4,  1'b0, STATUS_OK,       8'h00, 1'b0},
      '{MODE_OPEN_WRITE,  15'd0,     16'd64,    8'h00, 6'd1,  1'b1, STATUS_OK,       8'h00, 1'b0},
      '{MODE_WRITE_BYTE,  15'd0,     16'd0,     8'h5A, 6'd5,  1'b0, STATUS_OK,       8'h00, 1'b0},
      '{MODE_OPEN_READ,   15'd1,     16'd32768, 8'h00, 6'd1,  1'b1, STATUS_REJECT,   8'h00, 1'b0},
      '{MODE_READ_BYTE,   15'd0,     16'd0,     8'h00, 6'd1,  1'b1, STATUS_NO_XFER,  8'h00, 1'b0},
      '{MODE_ERASE,       15'd0,     16'd32768, 8'h00, 6'd1,  1'b1, STATUS_OK,       8'h00, 1'b0},
      '{MODE_OPEN_VERIFY, 15'd32767, 16'd1,     8'h00, 6'd1,  1'b1, STATUS_OK,       8'h00, 1'b0},
      '{MODE_VERIFY_BYTE, 15'd0,     16'd0,     8'hFF, 6'd1,  1'b1, STATUS_OK,       8'h00, 1'b1}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [MODE_W-1:0]      req_mode = '0;
   logic [ADDR_W-1:0]      req_address = '0;
   logic [LEN_W-1:0]       req_length = '0;
   logic [DATA_W-1:0]      req_data_byte = '0;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [DATA_W-1:0]      rsp_read_data;
   logic                   rsp_transfer_done;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   flash_region_command_engine #(
      .DEVICE_BYTES(DEVICE_BYTES),
      .PAGE_BYTES(PAGE_BYTES),
      .SECTOR_BYTES(SECTOR_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_address(req_address),
      .req_length(req_length),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_read_data(rsp_read_data),
      .rsp_transfer_done(rsp_transfer_done),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Mirror of the engine state, advanced once per accepted command.
   logic [DATA_W-1:0] mirror_store [DEVICE_BYTES];
   logic [DATA_W-1:0] page_bytes [PAGE_BYTES];
   logic [ADDR_W-1:0] xfer_cursor;
   logic [LEN_W-1:0]  xfer_left;
   kind_type          xfer_kind;
   int                page_count;
   logic [ADDR_W-1:0] page_origin;
   logic [ADDR_W-1:0] window_base;
   logic [LEN_W-1:0]  window_size;

   outcome_t pending_outcomes [$];
   int       error_count = 0;
   int       items_sent = 0;
   int       burst_left = 0;
   bit       start_high = 1'b0;
   int       cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic logic [ADDR_W-1:0] device_index(input int offset);
      return ADDR_W'((int'(window_base) + offset) % DEVICE_BYTES);
   endfunction

   function automatic void step_cursor();
      xfer_cursor = xfer_cursor + 1'b1;
      xfer_left = xfer_left - 1'b1;
   endfunction

   task automatic predict_outcome(input command_t c, output outcome_t r);
      bit range_bad;
      r = '{STATUS_OK, 8'h00, 1'b0};
      range_bad = (c.length == 0) || (int'(c.address) + int'(c.length) > int'(window_size));
      case (c.mode)
         MODE_ERASE: begin
            if (range_bad || (c.address % SECTOR_BYTES) != 0 || (c.length % SECTOR_BYTES) != 0) begin
               r.status = STATUS_REJECT;
            end else begin
               for (int i = 0; i < int'(c.length); i++)
                  mirror_store[device_index(int'(c.address) + i)] = ERASED_BYTE;
            end
         end
         MODE_OPEN_WRITE, MODE_OPEN_READ, MODE_OPEN_VERIFY: begin
            if (range_bad || (c.mode == MODE_OPEN_WRITE &&
                  ((c.address % PAGE_BYTES) != 0 || (c.length % PAGE_BYTES) != 0))) begin
               r.status = STATUS_REJECT;
               xfer_kind = KIND_NONE;
            end else begin
               xfer_kind = (c.mode == MODE_OPEN_WRITE) ? KIND_WRITE :
                           (c.mode == MODE_OPEN_READ) ? KIND_READ : KIND_VERIFY;
               xfer_cursor = c.address;
               xfer_left = c.length;
               page_count = 0;
               page_origin = c.address;
            end
         end
         MODE_WRITE_BYTE: begin
            if (xfer_kind != KIND_WRITE) begin
               r.status = STATUS_NO_XFER;
            end else begin
               if (page_count == 0) page_origin = xfer_cursor;
               page_bytes[page_count % PAGE_BYTES] = c.data_byte;
               page_count++;
               step_cursor();
               if (page_count >= PAGE_BYTES) begin
                  for (int i = 0; i < PAGE_BYTES; i++)
                     mirror_store[device_index(int'(page_origin) + i)] = page_bytes[i];
                  page_count = 0;
               end
               if (xfer_left == 0) begin
                  r.done = 1'b1;
                  xfer_kind = KIND_NONE;
                  page_count = 0;
               end
            end
         end
         MODE_READ_BYTE: begin
            if (xfer_kind != KIND_READ) begin
               r.status = STATUS_NO_XFER;
            end else begin
               r.read_data = mirror_store[device_index(int'(xfer_cursor))];
               step_cursor();
               if (xfer_left == 0) begin
                  r.done = 1'b1;
                  xfer_kind = KIND_NONE;
               end
            end
         end
         MODE_VERIFY_BYTE: begin
            if (xfer_kind != KIND_VERIFY) begin
               r.status = STATUS_NO_XFER;
            end else if (mirror_store[device_index(int'(xfer_cursor))] != c.data_byte) begin
               // A mismatch ends the transfer without moving the cursor.
               r.status = STATUS_MISMATCH;
               r.done = 1'b1;
               xfer_kind = KIND_NONE;
            end else begin
               step_cursor();
               if (xfer_left == 0) begin
                  r.done = 1'b1;
                  xfer_kind = KIND_NONE;
               end
            end
         end
         default: r.status = STATUS_REJECT;
      endcase
   endtask

   // Drives one command and waits until the engine accepts it; the sender then either keeps start
   // high for the next command of the burst or drops it for a random gap.
   task automatic send_command(input command_t c, input bit typed, input outcome_t typed_out);
      outcome_t predicted;
      req_mode <= c.mode;
      req_address <= c.address;
      req_length <= c.length;
      req_data_byte <= c.data_byte;
      start <= 1'b1;
      start_high = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predict_outcome(c, predicted);
      pending_outcomes.push_back(typed ? typed_out : predicted);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         start_high = 1'b0;
         repeat (($urandom_range(0, 4) == 0) ? $urandom_range(7, 45) : $urandom_range(1, 6))
            @(posedge clock);
         case ($urandom_range(0, 3))
            0: burst_left = $urandom_range(0, 2);
            1: burst_left = $urandom_range(3, 12);
            2: burst_left = $urandom_range(40, 120);
            default: burst_left = 0;
         endcase
      end
   endtask

   task automatic drop_start();
      if (start_high) begin
         start <= 1'b0;
         start_high = 1'b0;
      end
   endtask

   task automatic issue(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] address,
                        input logic [LEN_W-1:0] length, input logic [DATA_W-1:0] data_byte);
      send_command('{mode, address, length, data_byte}, 1'b0, '0);
   endtask

   task automatic send_noise();
      issue(MODE_W'($urandom_range(0, 7)), ADDR_W'($urandom_range(0, 32767)),
            LEN_W'($urandom_range(0, 65535)), DATA_W'($urandom_range(0, 255)));
   endtask

   // Occasionally breaks into a transfer with an unrelated command.
   task automatic maybe_stray();
      if ($urandom_range(0, 29) == 0) send_noise();
   endtask

   function automatic logic [ADDR_W-1:0] pick_offset(input int span, input int align);
      int room;
      room = int'(window_size) - span;
      if (room < 0) return ADDR_W'($urandom_range(0, 32767));
      return ADDR_W'(align * $urandom_range(0, room / align));
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (index == CSR_REGION_BASE) window_base = value[ADDR_W-1:0];
      else window_size = value;
   endtask

   // Registers change only with the engine idle: results drained, then a settle pause.
   task automatic configure(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] size);
      drop_start();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      write_register(CSR_REGION_BASE, {1'($urandom_range(0, 1)), base});
      write_register(CSR_REGION_SIZE, size);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      plan_row_t row;
      for (int r = 0; r < PLAN_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         for (int k = 0; k < int'(row.repeats); k++)
            send_command('{row.mode, row.address, row.length, row.data_byte + DATA_W'(k)},
                         row.typed, '{row.status, row.read_data, row.done});
      end
   endtask

   task automatic run_random(input int count);
      int goal;
      int pick;
      int span;
      int steps;
      logic [ADDR_W-1:0] origin;
      logic [DATA_W-1:0] value;
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            span = PAGE_BYTES * $urandom_range(1, 3);
            origin = pick_offset(span, PAGE_BYTES);
            issue(MODE_OPEN_WRITE, origin, LEN_W'(span), 8'h00);
            steps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span) : span;
            for (int k = 0; k < steps; k++) begin
               maybe_stray();
               issue(MODE_WRITE_BYTE, 15'd0, 16'd0, DATA_W'($urandom_range(0, 255)));
            end
         end else if (pick < 45) begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 32768) : $urandom_range(1, 40);
            origin = pick_offset(span, 1);
            issue(MODE_OPEN_READ, origin, LEN_W'(span), 8'h00);
            steps = (span > 40 || $urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : span;
            for (int k = 0; k < steps; k++) begin
               maybe_stray();
               issue(MODE_READ_BYTE, 15'd0, 16'd0, 8'h00);
            end
         end else if (pick < 65) begin
            span = $urandom_range(1, 40);
            origin = pick_offset(span, 1);
            issue(MODE_OPEN_VERIFY, origin, LEN_W'(span), 8'h00);
            for (int k = 0; k < span; k++) begin
               maybe_stray();
               value = mirror_store[device_index(int'(origin) + k)];
               if ($urandom_range(0, 19) == 0) value = DATA_W'($urandom_range(0, 255));
               issue(MODE_VERIFY_BYTE, 15'd0, 16'd0, value);
               if (xfer_kind == KIND_NONE) break;
            end
         end else if (pick < 75) begin
            // Mostly a few sectors; a large erase of up to 512 sectors is rare because it is slow.
            span = SECTOR_BYTES * (($urandom_range(0, 49) == 0) ? $urandom_range(1, 512)
                                                                 : $urandom_range(1, 4));
            origin = pick_offset(span, SECTOR_BYTES);
            if ($urandom_range(0, 9) == 0) origin = origin ^ ADDR_W'(1 << $urandom_range(0, 5));
            issue(MODE_ERASE, origin, LEN_W'(span), 8'h00);
         end else begin
            send_noise();
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      outcome_t want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result with no command outstanding");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_read_data !== want.read_data)
               report_mismatch($sformatf("read_data %02h, expected %02h",
                                         rsp_read_data, want.read_data));
            if (rsp_transfer_done !== want.done)
               report_mismatch($sformatf("transfer_done %0b, expected %0b",
                                         rsp_transfer_done, want.done));
         end
      end
   end

   initial begin
      for (int i = 0; i < DEVICE_BYTES; i++) mirror_store[i] = ERASED_BYTE;
      for (int i = 0; i < PAGE_BYTES; i++) page_bytes[i] = '0;
      xfer_cursor = '0;
      xfer_left = '0;
      xfer_kind = KIND_NONE;
      page_count = 0;
      page_origin = '0;
      window_base = '0;
      window_size = REGION_SIZE_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      configure(15'd0, REGION_SIZE_RESET);
      run_directed();
      run_random(200);
      // Highest base: nearly every device address wraps past the end of the store.
      configure(15'h7FFF, REGION_SIZE_RESET);
      run_random(200);
      configure(15'd0, 16'd0);
      run_random(40);
      configure(ADDR_W'(SECTOR_BYTES * $urandom_range(0, 511)), LEN_W'($urandom_range(64, 8192)));
      run_random(200);
      configure(ADDR_W'($urandom_range(0, 32767)), LEN_W'($urandom_range(1, 300)));
      run_random(150);
      configure(ADDR_W'($urandom_range(0, 32767)), REGION_SIZE_RESET);
      run_random(200);

      drop_start();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
